// ----- design/psw_pkg.sv -----
// package: beat types, store entry layout, limits and controller states
package psw_pkg;

    localparam int MAX_JOBS = 16;
    localparam int IDX_W    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CNT_W    = $clog2(MAX_JOBS + 1);

    localparam logic [19:0] WAIT_MAX  = 20'hFFFFF;
    localparam logic [23:0] TWAIT_MAX = 24'hFFFFFF;
    localparam logic [24:0] TTAT_MAX  = 25'h1FFFFFF;
    localparam logic [20:0] ELAPSED_CAP = 21'h100000;

    typedef struct packed {
        logic [7:0]  job_id;
        logic [7:0]  job_priority;
        logic [15:0] burst_length;
        logic        is_last;
    } job_beat_t;

    typedef struct packed {
        logic [7:0]  out_id;
        logic [15:0] out_burst;
        logic [19:0] wait_time;
        logic [19:0] turnaround_time;
        logic [23:0] total_wait;
        logic [24:0] total_turnaround;
        logic        jobs_dropped;
        logic        last_result;
    } res_beat_t;

    typedef struct packed {
        logic [15:0] burst;
        logic [7:0]  prio;
        logic [7:0]  id;
    } entry_t;

    typedef enum logic [2:0] {
        ST_LOAD = 3'b001,
        ST_SCAN = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

endpackage

// ----- design/priority_schedule_wait_times.sv -----
// top level: non-preemptive priority scheduler with wait and turnaround times
//
// job channel (job_valid/job_ready/job): one beat loads one job into the job
// store, back to back. the beat with is_last set closes the set and
// starts the run; jobs beyond psw_pkg::MAX_JOBS are dropped and flagged.
// result channel (res_valid/res_ready/res): one beat per stored job, in
// descending priority, equal priorities in load order.
// each result comes from a full scan of the single-port job store, one
// entry read per cycle; each registered read is compared with the best
// entry so far, and after the last one the emit state loads the output
// register with the result.
// the last result carries the totals and last_result.
// a stalled receiver holds the output register; the next scan runs and its
// emit waits until the beat is taken. the next set may be loaded while the
// last result still waits to be taken.
// reset empties the store (count and drop flag to zero), no clearing pass.
module priority_schedule_wait_times
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 job_valid,
    output logic                 job_ready,
    input  psw_pkg::job_beat_t   job,
    output logic                 res_valid,
    input  logic                 res_ready,
    output psw_pkg::res_beat_t   res
);

    psw_pkg::entry_t mem [psw_pkg::MAX_JOBS];
    psw_pkg::entry_t rd_data_reg;

    psw_pkg::state_t state_reg, state_next;
    logic [psw_pkg::CNT_W-1:0] count_reg, count_next;
    logic [psw_pkg::CNT_W-1:0] issue_reg, issue_next;
    logic [psw_pkg::CNT_W-1:0] rank_reg, rank_next;
    logic ovf_reg, ovf_next;
    logic [psw_pkg::MAX_JOBS-1:0] done_reg, done_next;
    logic rd_valid_reg, rd_last_reg;
    logic [psw_pkg::IDX_W-1:0] rd_idx_reg;
    logic best_found_reg, best_found_next;
    logic out_valid_reg, out_valid_next;

    logic [7:0]  best_prio_reg, best_prio_next;
    logic [7:0]  best_id_reg, best_id_next;
    logic [15:0] best_burst_reg, best_burst_next;
    logic [psw_pkg::IDX_W-1:0] best_idx_reg, best_idx_next;
    logic [20:0] elapsed_reg, elapsed_next;
    logic [23:0] sum_wait_reg, sum_wait_next;
    logic [24:0] sum_tat_reg, sum_tat_next;
    psw_pkg::res_beat_t out_reg, out_next;

    logic we;
    logic rd_en;
    logic out_load;
    logic last_res;
    logic [19:0] wait_now;
    logic [21:0] tat_sum;
    logic [19:0] tat_now;
    logic [24:0] sw_sum;
    logic [25:0] st_sum;

    assign job_ready = (state_reg == psw_pkg::ST_LOAD);
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    assign rd_en    = (state_reg == psw_pkg::ST_SCAN) && (issue_reg < count_reg);
    assign last_res = ((rank_reg + psw_pkg::CNT_W'(1)) == count_reg);

    // saturating schedule arithmetic
    assign wait_now = (elapsed_reg > {1'b0, psw_pkg::WAIT_MAX}) ? psw_pkg::WAIT_MAX
                                                                 : elapsed_reg[19:0];
    assign tat_sum  = {1'b0, elapsed_reg} + {6'd0, best_burst_reg};
    assign tat_now  = (tat_sum > {2'b00, psw_pkg::WAIT_MAX}) ? psw_pkg::WAIT_MAX
                                                             : tat_sum[19:0];
    assign sw_sum   = {1'b0, sum_wait_reg} + {5'd0, wait_now};
    assign st_sum   = {1'b0, sum_tat_reg} + {6'd0, tat_now};

    // job store
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[count_reg[psw_pkg::IDX_W-1:0]] <= '{burst: job.burst_length,
                                                    prio:  job.job_priority,
                                                    id:    job.job_id};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[issue_reg[psw_pkg::IDX_W-1:0]];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        issue_next      = issue_reg;
        rank_next       = rank_reg;
        ovf_next        = ovf_reg;
        done_next       = done_reg;
        best_found_next = best_found_reg;
        best_prio_next  = best_prio_reg;
        best_id_next    = best_id_reg;
        best_burst_next = best_burst_reg;
        best_idx_next   = best_idx_reg;
        elapsed_next    = elapsed_reg;
        sum_wait_next   = sum_wait_reg;
        sum_tat_next    = sum_tat_reg;
        out_next        = out_reg;
        we              = 1'b0;
        out_load        = 1'b0;

        unique case (state_reg)
            psw_pkg::ST_LOAD:
            begin
                if (job_valid)
                begin
                    if (count_reg < psw_pkg::CNT_W'(psw_pkg::MAX_JOBS))
                    begin
                        we         = 1'b1;
                        count_next = count_reg + psw_pkg::CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (job.is_last)
                    begin
                        state_next      = psw_pkg::ST_SCAN;
                        done_next       = '0;
                        elapsed_next    = '0;
                        sum_wait_next   = '0;
                        sum_tat_next    = '0;
                        rank_next       = '0;
                        issue_next      = '0;
                        best_found_next = 1'b0;
                    end
                end
            end
            psw_pkg::ST_SCAN:
            begin
                if (rd_en)
                begin
                    issue_next = issue_reg + psw_pkg::CNT_W'(1);
                end
                if (rd_valid_reg)
                begin
                    // strict compare keeps the earliest loaded job on ties
                    if (!done_reg[rd_idx_reg] &&
                        (!best_found_reg || (rd_data_reg.prio > best_prio_reg)))
                    begin
                        best_found_next = 1'b1;
                        best_prio_next  = rd_data_reg.prio;
                        best_id_next    = rd_data_reg.id;
                        best_burst_next = rd_data_reg.burst;
                        best_idx_next   = rd_idx_reg;
                    end
                    if (rd_last_reg)
                    begin
                        state_next = psw_pkg::ST_EMIT;
                    end
                end
            end
            psw_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || res_ready)
                begin
                    out_load                 = 1'b1;
                    done_next[best_idx_reg]  = 1'b1;
                    elapsed_next             = (tat_sum > {1'b0, psw_pkg::ELAPSED_CAP})
                                             ? psw_pkg::ELAPSED_CAP : tat_sum[20:0];
                    sum_wait_next            = (sw_sum > {1'b0, psw_pkg::TWAIT_MAX})
                                             ? psw_pkg::TWAIT_MAX : sw_sum[23:0];
                    sum_tat_next             = (st_sum > {1'b0, psw_pkg::TTAT_MAX})
                                             ? psw_pkg::TTAT_MAX : st_sum[24:0];
                    rank_next                = rank_reg + psw_pkg::CNT_W'(1);
                    out_next.out_id          = best_id_reg;
                    out_next.out_burst       = best_burst_reg;
                    out_next.wait_time       = wait_now;
                    out_next.turnaround_time = tat_now;
                    out_next.jobs_dropped    = ovf_reg;
                    out_next.last_result     = last_res;
                    out_next.total_wait      = '0;
                    out_next.total_turnaround = '0;
                    if (last_res)
                    begin
                        out_next.total_wait       = sum_wait_next;
                        out_next.total_turnaround = sum_tat_next;
                        state_next = psw_pkg::ST_LOAD;
                        count_next = '0;
                        ovf_next   = 1'b0;
                    end
                    else
                    begin
                        state_next      = psw_pkg::ST_SCAN;
                        issue_next      = '0;
                        best_found_next = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = psw_pkg::ST_LOAD;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= psw_pkg::ST_LOAD;
            count_reg      <= '0;
            issue_reg      <= '0;
            rank_reg       <= '0;
            ovf_reg        <= 1'b0;
            done_reg       <= '0;
            rd_valid_reg   <= 1'b0;
            rd_last_reg    <= 1'b0;
            rd_idx_reg     <= '0;
            best_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            issue_reg      <= issue_next;
            rank_reg       <= rank_next;
            ovf_reg        <= ovf_next;
            done_reg       <= done_next;
            rd_valid_reg   <= rd_en;
            rd_last_reg    <= rd_en && (issue_reg == (count_reg - psw_pkg::CNT_W'(1)));
            rd_idx_reg     <= issue_reg[psw_pkg::IDX_W-1:0];
            best_found_reg <= best_found_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        best_prio_reg  <= best_prio_next;
        best_id_reg    <= best_id_next;
        best_burst_reg <= best_burst_next;
        best_idx_reg   <= best_idx_next;
        elapsed_reg    <= elapsed_next;
        sum_wait_reg   <= sum_wait_next;
        sum_tat_reg    <= sum_tat_next;
        out_reg        <= out_next;
    end

endmodule

// ----- sim/schedule_checker.sv -----
// checker: predicts the job schedule from accepted job beats and compares result beats
`timescale 1ns / 1ps

module schedule_checker
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_valid,
    input  logic                job_ready,
    input  psw_pkg::job_beat_t  job,
    input  logic                res_valid,
    input  logic                res_ready,
    input  psw_pkg::res_beat_t  res,
    output int                  errors,
    output int                  pending
);

    psw_pkg::entry_t     job_store [psw_pkg::MAX_JOBS];
    int                  stored;
    logic                dropped;
    psw_pkg::res_beat_t  expected_schedule [$];

    function automatic longint unsigned clip(input longint unsigned v,
                                             input longint unsigned top);
        return (v > top) ? top : v;
    endfunction

    task automatic report_mismatch(input string field, input longint unsigned got,
                                   input longint unsigned want);
        $display("%0t ns  %s: got %0h, expected %0h", $time, field, got, want);
        errors++;
    endtask

    // stores one job; the closing beat orders the set and queues its results
    task automatic load_job(input psw_pkg::job_beat_t b);
        psw_pkg::entry_t     order [psw_pkg::MAX_JOBS];
        psw_pkg::entry_t     e;
        psw_pkg::res_beat_t  r;
        longint unsigned     elapsed;
        longint unsigned     sum_wait;
        longint unsigned     sum_tat;
        longint unsigned     wait_v;
        longint unsigned     tat_v;
        int                  n;
        int                  j;

        if (stored < psw_pkg::MAX_JOBS)
        begin
            job_store[stored] = '{burst: b.burst_length, prio: b.job_priority,
                                  id: b.job_id};
            stored++;
        end
        else
            dropped = 1'b1;

        if (!b.is_last)
            return;

        n = stored;
        // stable insertion sort, highest priority first
        for (int i = 0; i < n; i++)
        begin
            e = job_store[i];
            j = i;
            while (j > 0 && order[j - 1].prio < e.prio)
            begin
                order[j] = order[j - 1];
                j--;
            end
            order[j] = e;
        end

        elapsed = 0;
        sum_wait = 0;
        sum_tat = 0;
        for (int i = 0; i < n; i++)
        begin
            wait_v = clip(elapsed, psw_pkg::WAIT_MAX);
            tat_v = clip(elapsed + order[i].burst, psw_pkg::WAIT_MAX);
            elapsed += order[i].burst;
            sum_wait += wait_v;
            sum_tat += tat_v;
            r = '0;
            r.out_id = order[i].id;
            r.out_burst = order[i].burst;
            r.wait_time = wait_v[19:0];
            r.turnaround_time = tat_v[19:0];
            r.jobs_dropped = dropped;
            if (i == n - 1)
            begin
                r.total_wait = 24'(clip(sum_wait, psw_pkg::TWAIT_MAX));
                r.total_turnaround = 25'(clip(sum_tat, psw_pkg::TTAT_MAX));
                r.last_result = 1'b1;
            end
            expected_schedule.push_back(r);
        end
        stored = 0;
        dropped = 1'b0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        psw_pkg::res_beat_t want;
        if (!rst_n)
        begin
            stored = 0;
            dropped = 1'b0;
            errors = 0;
            expected_schedule.delete();
            pending <= 0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                if (expected_schedule.size() == 0)
                    report_mismatch("result beat with nothing expected, out_id",
                                    res.out_id, 0);
                else
                begin
                    want = expected_schedule.pop_front();
                    if (res.out_id !== want.out_id)
                        report_mismatch("out_id", res.out_id, want.out_id);
                    if (res.out_burst !== want.out_burst)
                        report_mismatch("out_burst", res.out_burst, want.out_burst);
                    if (res.wait_time !== want.wait_time)
                        report_mismatch("wait_time", res.wait_time, want.wait_time);
                    if (res.turnaround_time !== want.turnaround_time)
                        report_mismatch("turnaround_time", res.turnaround_time,
                                        want.turnaround_time);
                    if (res.total_wait !== want.total_wait)
                        report_mismatch("total_wait", res.total_wait, want.total_wait);
                    if (res.total_turnaround !== want.total_turnaround)
                        report_mismatch("total_turnaround", res.total_turnaround,
                                        want.total_turnaround);
                    if (res.jobs_dropped !== want.jobs_dropped)
                        report_mismatch("jobs_dropped", res.jobs_dropped,
                                        want.jobs_dropped);
                    if (res.last_result !== want.last_result)
                        report_mismatch("last_result", res.last_result,
                                        want.last_result);
                end
            end
            if (job_valid && job_ready)
                load_job(job);
            pending <= expected_schedule.size();
        end
    end

endmodule

// ----- sim/priority_schedule_wait_times_tb.sv -----
// testbench top: clock, reset, job stimulus, result stalls and the verdict
`timescale 1ns / 1ps

module priority_schedule_wait_times_tb;

    localparam int ITEMS = 420;
    localparam int LIMIT = 400000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                job_valid = 1'b0;
    logic                job_ready;
    psw_pkg::job_beat_t  job = '0;
    logic                res_valid;
    logic                res_ready = 1'b0;
    psw_pkg::res_beat_t  res;

    int         errors;
    int         pending;
    int         idle_pct = 0;
    int         stall_pct = 0;
    int         items_sent = 0;
    int         cycles = 0;

    priority_schedule_wait_times DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    schedule_checker schedule_check
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .errors    (errors),
        .pending   (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        res_ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("priority_schedule_wait_times: mismatch");
            $finish;
        end
    end

    // called at a rising edge; returns at the edge where the beat is taken
    task automatic send_job(input logic [7:0] id, input logic [7:0] prio,
                            input logic [15:0] burst, input logic last);
        while ($urandom_range(99) < idle_pct)
        begin
            job_valid <= 1'b0;
            @(posedge clk);
        end
        job_valid <= 1'b1;
        job <= '{job_id: id, job_priority: prio, burst_length: burst, is_last: last};
        @(posedge clk);
        while (!job_ready)
            @(posedge clk);
        items_sent++;
    endtask

    initial
    begin
        int          set_size;
        int          prio_mode;
        int          phase;
        logic [7:0]  prio;
        logic [15:0] burst;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single job at the top of every field
        send_job(8'hFF, 8'hFF, 16'hFFFF, 1'b1);
        // zero fields, a priority tie kept in load order, zero burst
        send_job(8'h00, 8'h00, 16'h0000, 1'b0);
        send_job(8'h55, 8'h80, 16'h0001, 1'b0);
        send_job(8'hAA, 8'h80, 16'h8000, 1'b0);
        send_job(8'h7F, 8'h01, 16'h7FFF, 1'b1);
        // full store of equal priorities, closing beat dropped but starts the run
        for (int k = 0; k < psw_pkg::MAX_JOBS + 1; k++)
            send_job(k[7:0], 8'h40, 16'hFFFF, k == psw_pkg::MAX_JOBS);

        while (items_sent < ITEMS)
        begin
            phase = items_sent * 4 / ITEMS;
            if (phase == 0)
            begin
                idle_pct = 0;
                stall_pct = 0;
            end
            else if (phase == 1)
            begin
                idle_pct = 50;
                stall_pct = 0;
            end
            else if (phase == 2)
            begin
                idle_pct = 0;
                stall_pct = 50;
            end
            else
            begin
                idle_pct = 16;
                stall_pct = 16;
            end

            if ($urandom_range(9) == 0)
                set_size = $urandom_range(psw_pkg::MAX_JOBS + 4, psw_pkg::MAX_JOBS + 1);
            else
                set_size = $urandom_range(psw_pkg::MAX_JOBS, 1);
            prio_mode = $urandom_range(2);
            for (int k = 0; k < set_size; k++)
            begin
                if (prio_mode == 0)
                    prio = 8'($urandom_range(255));
                else if (prio_mode == 1)
                    prio = 8'($urandom_range(3));
                else
                    prio = $urandom_range(1) ? 8'hFF : 8'h00;
                if ($urandom_range(1))
                    burst = 16'($urandom_range(65535));
                else
                    burst = 16'($urandom_range(255));
                send_job(8'($urandom_range(255)), prio, burst, k == set_size - 1);
            end
        end
        job_valid <= 1'b0;

        do
            @(posedge clk);
        while (pending != 0);
        repeat (40) @(posedge clk);

        if (errors == 0 && pending == 0)
            $display("priority_schedule_wait_times: match");
        else
            $display("priority_schedule_wait_times: mismatch");
        $finish;
    end

endmodule

// ----- files.f -----
design/psw_pkg.sv
design/priority_schedule_wait_times.sv
sim/schedule_checker.sv
sim/priority_schedule_wait_times_tb.sv
